[rtl/hcfh_pkg.sv]
// ----------------------------------------------------------------------------
// hcfh_pkg: shared definitions of the frame hunter
// Widths, register indexes, reset values and the per-cell control bundle.
// ----------------------------------------------------------------------------
package hcfh_pkg;

  localparam int BYTE_W           = 8;
  localparam int FILL_W           = 4;
  localparam int DATA_W           = 64;
  localparam int DROP_W           = 4;
  localparam int ERR_W            = 32;
  localparam int CFG_IDX_W        = 8;
  localparam int FRAME_LENGTH_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

  // Control that every cell of the window sees in the same cycle.
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [FILL_W-1:0] fill;
  } cell_ctl_t;

endpackage

[rtl/hcfh_in_if.sv]
// ----------------------------------------------------------------------------
// hcfh_in_if: received byte channel
// Valid/ready channel carrying one received byte per beat.
// ----------------------------------------------------------------------------
interface hcfh_in_if;
  import hcfh_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/hcfh_out_if.sv]
// ----------------------------------------------------------------------------
// hcfh_out_if: result channel
// Valid/ready channel carrying one hunt result per beat.
// ----------------------------------------------------------------------------
interface hcfh_out_if;
  import hcfh_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_found;
  logic [DATA_W-1:0] frame_data;
  logic [DROP_W-1:0] bytes_dropped;
  logic [ERR_W-1:0]  error_total;

  modport source (output valid, output frame_found, output frame_data,
                  output bytes_dropped, output error_total, input ready);
  modport sink   (input valid, input frame_found, input frame_data,
                  input bytes_dropped, input error_total, output ready);
endinterface

[rtl/hcfh_cfg_if.sv]
// ----------------------------------------------------------------------------
// hcfh_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface hcfh_cfg_if;
  import hcfh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/hcfh_cell.sv]
// ----------------------------------------------------------------------------
// hcfh_cell: one byte position of the candidate window
// Holds one byte, takes its right neighbor's byte on a shift, loads a new
// byte when the fill count points at it, and extends the running sum.
// ----------------------------------------------------------------------------
module hcfh_cell
  import hcfh_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] right_byte,
  input  logic [BYTE_W-1:0] sum_in,
  output logic [BYTE_W-1:0] byte_q,
  output logic [BYTE_W-1:0] sum_out
);

  localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(CELL_IDX);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) begin
      byte_nxt = right_byte;
    end else if (ctl.load && (ctl.fill == MY_IDX)) begin
      byte_nxt = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q  = byte_r;
  assign sum_out = sum_in + byte_r;

endmodule

[rtl/header_checksum_frame_hunter_core.sv]
// ----------------------------------------------------------------------------
// header_checksum_frame_hunter_core: sliding-window frame synchronizer
// Hunts for header-plus-checksum frames in a received byte stream.
// ----------------------------------------------------------------------------
// Each accepted input beat appends one byte to a window of FRAME_LENGTH byte
// cells and produces exactly one result beat. After the byte is loaded, the
// hunt examines the window once per clock: with two bytes held, a byte is
// dropped whenever the first byte misses header_first, the second misses
// header_second, or a full window fails its checksum (last byte equal to the
// 8-bit sum of the others). A full window that passes is reported in
// frame_data and the window empties. An item is thus loaded, then shifted
// by one cell position for each dropped byte, and then its result is posted.
// The input is taken again as soon as the result sits in the output
// register, even if the sink has not taken it yet; a hunt that finishes
// while the previous result still waits holds until that beat leaves.
// Configuration writes are always ready and take effect at once; write them
// only while the block is idle. Drops add to error_total, which saturates
// at all ones.
// ----------------------------------------------------------------------------
module header_checksum_frame_hunter_core
  import hcfh_pkg::*;
#(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcfh_in_if.sink     in_ch,
  hcfh_out_if.source  out_ch,
  hcfh_cfg_if.sink    cfg_ch
);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LENGTH);
  localparam logic [FILL_W-1:0] FILL_PAIR = FILL_W'(2);

  typedef enum logic {
    ST_IDLE,
    ST_HUNT
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [BYTE_W-1:0] hdr_first_r, hdr_first_nxt;
  logic [BYTE_W-1:0] hdr_second_r, hdr_second_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [DROP_W-1:0] out_drop_r, out_drop_nxt;
  logic [ERR_W-1:0]  out_err_r, out_err_nxt;

  // Cell row: byte storage and the running checksum chain.
  logic [BYTE_W-1:0] win_byte [FRAME_LENGTH];
  logic [BYTE_W-1:0] win_sum  [FRAME_LENGTH];
  cell_ctl_t         cell_ctl;
  logic              do_shift;
  logic              do_load;
  logic              hunt_done;
  logic              hunt_found;
  logic              out_free;
  logic [DATA_W-1:0] frame_word;

  genvar gi;
  generate
    for (gi = 0; gi < FRAME_LENGTH; gi++) begin : g_cell
      logic [BYTE_W-1:0] right_byte;
      logic [BYTE_W-1:0] sum_in;

      if (gi == FRAME_LENGTH - 1) begin : g_last
        assign right_byte = '0;
      end else begin : g_mid
        assign right_byte = win_byte[gi+1];
      end

      if (gi == 0) begin : g_first
        assign sum_in = '0;
      end else begin : g_rest
        assign sum_in = win_sum[gi-1];
      end

      hcfh_cell #(
        .CELL_IDX (gi)
      ) u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .rx_byte    (in_ch.rx_byte),
        .right_byte (right_byte),
        .sum_in     (sum_in),
        .byte_q     (win_byte[gi]),
        .sum_out    (win_sum[gi])
      );
    end
  endgenerate

  assign cell_ctl.shift = do_shift;
  assign cell_ctl.load  = do_load;
  assign cell_ctl.fill  = fill_r;

  // Frame image: byte i in bits 8i+7..8i, unused upper bytes zero.
  always_comb begin
    frame_word = '0;
    for (int i = 0; i < FRAME_LENGTH; i++) begin
      frame_word[i*BYTE_W +: BYTE_W] = win_byte[i];
    end
  end

  // The output register is free when empty or when its beat leaves now.
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    drop_nxt       = drop_r;
    err_nxt        = err_r;
    hdr_first_nxt  = hdr_first_r;
    hdr_second_nxt = hdr_second_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_data_nxt   = out_data_r;
    out_drop_nxt   = out_drop_r;
    out_err_nxt    = out_err_r;
    do_shift       = 1'b0;
    do_load        = 1'b0;
    hunt_done      = 1'b0;
    hunt_found     = 1'b0;

    if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_HEADER_FIRST) begin
        hdr_first_nxt = cfg_ch.data;
      end else if (cfg_ch.index == REG_HEADER_SECOND) begin
        hdr_second_nxt = cfg_ch.data;
      end
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          do_load   = 1'b1;
          fill_nxt  = fill_r + FILL_W'(1);
          drop_nxt  = '0;
          state_nxt = ST_HUNT;
        end
      end
      ST_HUNT: begin
        if (fill_r < FILL_PAIR) begin
          hunt_done = 1'b1;
        end else if ((win_byte[0] != hdr_first_r) || (win_byte[1] != hdr_second_r)) begin
          do_shift = 1'b1;
        end else if (fill_r < FILL_FULL) begin
          hunt_done = 1'b1;
        end else if (win_sum[FRAME_LENGTH-2] == win_byte[FRAME_LENGTH-1]) begin
          hunt_done  = 1'b1;
          hunt_found = 1'b1;
        end else begin
          do_shift = 1'b1;
        end

        if (do_shift) begin
          fill_nxt = fill_r - FILL_W'(1);
          drop_nxt = drop_r + DROP_W'(1);
          if (err_r != '1) begin
            err_nxt = err_r + ERR_W'(1);
          end
        end

        if (hunt_done && out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hunt_found;
          out_data_nxt  = hunt_found ? frame_word : '0;
          out_drop_nxt  = drop_r;
          out_err_nxt   = err_r;
          if (hunt_found) begin
            fill_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      drop_r       <= '0;
      err_r        <= '0;
      hdr_first_r  <= HEADER_FIRST_RST;
      hdr_second_r <= HEADER_SECOND_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      drop_r       <= drop_nxt;
      err_r        <= err_nxt;
      hdr_first_r  <= hdr_first_nxt;
      hdr_second_r <= hdr_second_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_found_r <= out_found_nxt;
    out_data_r  <= out_data_nxt;
    out_drop_r  <= out_drop_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_found   = out_found_r;
  assign out_ch.frame_data    = out_data_r;
  assign out_ch.bytes_dropped = out_drop_r;
  assign out_ch.error_total   = out_err_r;

endmodule

[test/tb_header_checksum_frame_hunter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_header_checksum_frame_hunter_core: self-checking bench of the frame hunter
// Drives received bytes through the valid/ready input channel with random
// gaps, stalls the result channel at random, and compares every result beat
// with a hand-given result or a behavioral frame hunter kept in the bench. Header
// registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_header_checksum_frame_hunter_core
  import hcfh_pkg::*;
();

  localparam int FRAME_LEN   = FRAME_LENGTH_DEF;
  localparam int SETTLE_CYC  = FRAME_LEN + 4;   // worst hunt plus output slack
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 26;
  localparam int DIR_N       = 26;

  // Register indexes the block must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  // One result beat, as the predictor works it out.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] data;
    logic [DROP_W-1:0] dropped;
    logic [ERR_W-1:0]  total;
  } hunt_result_t;

  // One input beat; when typed is set the expected result is given by hand
  // in res, otherwise it comes from the predictor.
  typedef struct packed {
    logic              typed;
    logic [BYTE_W-1:0] b;
    hunt_result_t      res;
  } byte_beat_t;

  localparam hunt_result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hcfh_in_if  in_ch ();
  hcfh_out_if out_ch ();
  hcfh_cfg_if cfg_ch ();

  header_checksum_frame_hunter_core #(
    .FRAME_LENGTH(FRAME_LEN)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral frame hunter. It holds its own copy of the header registers,
  // the candidate window, its fill level and the saturating drop counter.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] hdr_first  = HEADER_FIRST_RST;
  logic [BYTE_W-1:0] hdr_second = HEADER_SECOND_RST;
  logic [BYTE_W-1:0] win [FRAME_LEN];
  int                win_fill  = 0;
  logic [ERR_W-1:0]  drop_total = '0;

  // Removes the oldest window byte; a counted drop bumps the error total,
  // which sticks at all ones.
  function automatic void drop_front(input bit counted);
    for (int i = 0; i < FRAME_LEN - 1; i++) win[i] = win[i + 1];
    win[FRAME_LEN - 1] = '0;
    if (win_fill != 0) win_fill--;
    if (counted && drop_total != '1) drop_total++;
  endfunction

  // Appends one received byte and hunts until the window is either waiting
  // for more bytes, down to a single byte, or has yielded a frame.
  function automatic hunt_result_t hunt_byte(input logic [BYTE_W-1:0] b);
    hunt_result_t      r;
    logic [BYTE_W-1:0] sum;
    int                drops;
    r = NO_RES;
    drops = 0;
    // The window is never full between beats; should it be, the oldest byte
    // makes room silently.
    if (win_fill >= FRAME_LEN) drop_front(1'b0);
    win[win_fill] = b;
    win_fill++;
    while (win_fill >= 2) begin
      if (win[0] != hdr_first || win[1] != hdr_second) begin
        drop_front(1'b1);
        drops++;
      end else if (win_fill < FRAME_LEN) begin
        break;
      end else begin
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += win[i];
        if (sum == win[FRAME_LEN - 1]) begin
          for (int i = 0; i < FRAME_LEN; i++) r.data[8*i +: 8] = win[i];
          r.found = 1'b1;
          win = '{default: '0};
          win_fill = 0;
          break;
        end
        drop_front(1'b1);
        drops++;
      end
    end
    r.dropped = DROP_W'(drops);
    r.total = drop_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed rows, run with the reset headers 0xAA 0x55. Rows whose result is
  // obvious carry it; the others are left to the predictor.
  // --------------------------------------------------------------------------
  byte_beat_t directed_rows [DIR_N] = '{
    // A lone byte is not judged until a second one arrives, even off-header.
    {1'b1, 8'h00, 1'b0, 64'h0, 4'd0, 32'd0},
    // Second byte forces the check: 0x00 misses the first header byte.
    {1'b1, 8'hFF, 1'b0, 64'h0, 4'd1, 32'd1},
    {1'b1, 8'hAA, 1'b0, 64'h0, 4'd1, 32'd2},
    {1'b1, 8'h55, 1'b0, 64'h0, 4'd0, 32'd2},
    {1'b0, 8'h01, NO_RES},
    {1'b0, 8'h02, NO_RES},
    {1'b0, 8'h03, NO_RES},
    {1'b0, 8'h04, NO_RES},
    {1'b0, 8'h05, NO_RES},
    // Correct checksum closes the first frame.
    {1'b1, 8'h0E, 1'b1, 64'h0E05_0403_0201_55AA, 4'd0, 32'd2},
    // Header then an all-ones body with a wrong checksum: the whole window
    // collapses to the last byte in one beat, with seven drops.
    {1'b0, 8'hAA, NO_RES},
    {1'b0, 8'h55, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b1, 8'h00, 1'b0, 64'h0, 4'd7, 32'd9},
    // Resynchronize behind the leftover byte and catch an all-ones frame.
    {1'b1, 8'hAA, 1'b0, 64'h0, 4'd1, 32'd10},
    {1'b0, 8'h55, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b0, 8'hFF, NO_RES},
    {1'b1, 8'hFA, 1'b1, 64'hFAFF_FFFF_FFFF_55AA, 4'd0, 32'd10}
  };

  byte_beat_t   bytes_to_send [$];
  hunt_result_t expected_results [$];
  byte_beat_t   cur_beat;
  hunt_result_t predicted;
  hunt_result_t want;
  int           mismatches = 0;
  bit           calm = 1'b0;   // when set, neither side idles
  int           cycle_count = 0;

  // --------------------------------------------------------------------------
  // Byte sender. A beat is taken at an edge where valid and ready are both
  // high; the predictor runs on it right there. The next byte is offered in
  // the same step so valid stays high across back-to-back beats.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = hunt_byte(in_ch.rx_byte);
        expected_results.push_back(cur_beat.typed ? cur_beat.res : predicted);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_beat = bytes_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= cur_beat.b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Counts a mismatch and reports it.
  function automatic void note_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s expected %h, got %h", $time, what, exp_v, got_v);
  endfunction

  // --------------------------------------------------------------------------
  // Result receiver with random back-pressure. Every accepted result beat is
  // checked field by field against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result beat with nothing pending, frame_data", '0, out_ch.frame_data);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.frame_found !== want.found)
          note_mismatch("frame_found", DATA_W'(want.found), DATA_W'(out_ch.frame_found));
        if (out_ch.frame_data !== want.data)
          note_mismatch("frame_data", want.data, out_ch.frame_data);
        if (out_ch.bytes_dropped !== want.dropped)
          note_mismatch("bytes_dropped", DATA_W'(want.dropped), DATA_W'(out_ch.bytes_dropped));
        if (out_ch.error_total !== want.total)
          note_mismatch("error_total", DATA_W'(want.total), DATA_W'(out_ch.error_total));
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_header_checksum_frame_hunter_core failed");
      $finish;
    end
  end

  // Writes one register. Valid stays high between consecutive writes and is
  // dropped at the handshake of the last one. The predictor takes the value
  // at the same edge as the block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                           input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_HEADER_FIRST:  hdr_first = val;
      REG_HEADER_SECOND: hdr_second = val;
      default: ;
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  // Queues a stream built mostly from well-formed frames under the current
  // headers, mixed with corrupted frames, cut-off frames and plain noise.
  task automatic queue_random(input int n);
    logic [BYTE_W-1:0] frm [FRAME_LEN];
    logic [BYTE_W-1:0] sum;
    int                kind;
    int                len;
    int                queued;
    queued = 0;
    while (queued < n) begin
      kind = $urandom_range(99);
      frm[0] = hdr_first;
      frm[1] = hdr_second;
      sum = hdr_first + hdr_second;
      for (int i = 2; i < FRAME_LEN - 1; i++) begin
        // A header byte inside the body now and then sets up a false sync.
        frm[i] = ($urandom_range(7) == 0) ? hdr_first : BYTE_W'($urandom);
        sum += frm[i];
      end
      frm[FRAME_LEN - 1] = sum;
      len = FRAME_LEN;
      if (kind >= 85) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) frm[i] = BYTE_W'($urandom);
      end else if (kind >= 70) begin
        len = $urandom_range(1, FRAME_LEN - 1);
      end else if (kind >= 55) begin
        frm[$urandom_range(FRAME_LEN - 1)] ^= BYTE_W'($urandom_range(1, 255));
      end
      for (int i = 0; i < len; i++) bytes_to_send.push_back(byte_beat_t'({1'b0, frm[i], NO_RES}));
      queued += len;
    end
  endtask

  // Waits until every queued byte has gone in and every result has come
  // out, then lets the block's worst hunt time pass before any rewrite.
  task automatic settle();
    while (bytes_to_send.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: directed rows and a random phase under the reset headers,
  // then phases under extreme, swapped, random and equal headers, and a
  // return to the reset values. The window and the error total carry over
  // from phase to phase, as they do in the block.
  // --------------------------------------------------------------------------
  initial begin
    logic [BYTE_W-1:0] same;
    win = '{default: '0};
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_N; k++) bytes_to_send.push_back(directed_rows[k]);
    queue_random(200);
    settle();

    // Lowest and highest header values; a write to an unused index must
    // leave both headers alone.
    write_reg(REG_HEADER_FIRST, 8'h00, 1'b0);
    write_reg(REG_HEADER_SECOND, 8'hFF, 1'b0);
    write_reg(REG_UNUSED_LOW, BYTE_W'($urandom), 1'b1);
    queue_random(200);
    settle();

    // Swapped extremes, run flat out on both sides.
    write_reg(REG_HEADER_FIRST, 8'hFF, 1'b0);
    write_reg(REG_HEADER_SECOND, 8'h00, 1'b1);
    calm = 1'b1;
    queue_random(200);
    settle();
    calm = 1'b0;

    write_reg(REG_HEADER_FIRST, BYTE_W'($urandom), 1'b0);
    write_reg(REG_UNUSED_TOP, BYTE_W'($urandom), 1'b0);
    write_reg(REG_HEADER_SECOND, BYTE_W'($urandom), 1'b1);
    queue_random(200);
    settle();

    // Both header bytes equal, so runs of that value keep re-syncing.
    same = BYTE_W'($urandom);
    write_reg(REG_HEADER_FIRST, same, 1'b0);
    write_reg(REG_HEADER_SECOND, same, 1'b1);
    queue_random(200);
    settle();

    write_reg(REG_HEADER_FIRST, HEADER_FIRST_RST, 1'b0);
    write_reg(REG_HEADER_SECOND, HEADER_SECOND_RST, 1'b1);
    queue_random(175);
    settle();

    if (mismatches == 0) begin
      $display("tb_header_checksum_frame_hunter_core passed");
    end else begin
      $display("tb_header_checksum_frame_hunter_core failed");
    end
    $finish;
  end

endmodule
